/* hdl/shsc_pkg.sv */
// Shared types and constants for the half-step stepper controller.
`timescale 1ns / 1ps

package shsc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CSR_INDEX_W = 2;

   // Reset values of the configuration registers
   localparam logic [DATA_W-1:0] STEP_INTERVAL_RESET = 32'd1464;
   localparam logic signed [DATA_W-1:0] LIMIT_CW_RESET = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] LIMIT_CCW_RESET = 32'sh0000_0000;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_INTERVAL = 2'd0,
      CSR_LIMIT_CW      = 2'd1,
      CSR_LIMIT_CCW     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_MOVE_CW  = 3'd1,
      OP_MOVE_CCW = 3'd2,
      OP_MOVE_TO  = 3'd3,
      OP_STOP     = 3'd4,
      OP_STEP_CW  = 3'd5,
      OP_STEP_CCW = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   // Phase mask bits that energize each coil, coil 3 first
   localparam logic [3:0][7:0] COIL_PATTERN = {8'hE0, 8'h0E, 8'h38, 8'h83};
   localparam logic [7:0] MASK_RESET = 8'h01;
   localparam logic [7:0] MASK_LOW = 8'h01;
   localparam logic [7:0] MASK_HIGH = 8'h80;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [DATA_W-1:0] amount;
      logic [DATA_W-1:0]        now_us;
   } req_type;

   typedef struct packed {
      logic [3:0]               coils;
      logic signed [DATA_W-1:0] position_now;
      logic                     stepped;
      logic                     busy_res;
   } rsp_type;

   // Outcome of one attempted step
   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] position;
      logic [7:0]               mask;
      logic [3:0]               coils;
   } step_type;

endpackage

/* hdl/shsc_step.sv */
// One half step: limit check, coil decode and phase mask rotation.
`timescale 1ns / 1ps

module shsc_step
   import shsc_pkg::*;
(
   input  logic signed [DATA_W-1:0] position,
   input  dir_type                  dir,
   input  logic [7:0]               mask,
   input  logic signed [DATA_W-1:0] limit_cw,
   input  logic signed [DATA_W-1:0] limit_ccw,
   output step_type                 result
);

   logic signed [DATA_W:0] delta;
   logic signed [DATA_W:0] next_pos;
   logic signed [DATA_W:0] lim_cw_ext;
   logic signed [DATA_W:0] lim_ccw_ext;
   logic [7:0]             mask_left;
   logic [7:0]             mask_right;
   logic [3:0]             coils;

   always_comb begin
      unique case (dir)
         DIR_CW:  delta = (DATA_W+1)'(1);
         DIR_CCW: delta = {(DATA_W+1){1'b1}};
         default: delta = '0;
      endcase
   end

   assign next_pos    = $signed({position[DATA_W-1], position}) + delta;
   assign lim_cw_ext  = $signed({limit_cw[DATA_W-1], limit_cw});
   assign lim_ccw_ext = $signed({limit_ccw[DATA_W-1], limit_ccw});

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         coils[i] = |(COIL_PATTERN[i] & mask);
      end
   end

   assign mask_left  = {mask[6:0], 1'b0};
   assign mask_right = {1'b0, mask[7:1]};

   always_comb begin
      result.ok = !(next_pos >= lim_cw_ext || next_pos <= lim_ccw_ext);
      result.position = next_pos[DATA_W-1:0];
      result.coils = coils;
      unique case (dir)
         DIR_CW:  result.mask = (mask_left == '0) ? MASK_LOW : mask_left;
         DIR_CCW: result.mask = (mask_right == '0) ? MASK_HIGH : mask_right;
         default: result.mask = mask;
      endcase
   end

endmodule

/* hdl/stepper_half_step_controller.sv */
// Top level of the half-step stepper controller: registers, commands and ports.
//
//   port group | dir | handshake          | word
//   req_       | in  | req_valid/req_stall | req_type: opcode, amount, now_us
//   rsp_       | out | rsp_valid/rsp_stall | rsp_type: coils, position_now, stepped, busy_res
//   csr_       | in  | csr_valid/csr_ready | csr_index, csr_data
//
// One word per cycle while the result is not stalled: input register, then one pass of
// logic that updates the motor state and loads the result register.
// Reset (synchronous) clears the state and loads the configuration defaults.
// A stalled result holds the input register; req_stall rises only then.
// csr_ready is always high.
`timescale 1ns / 1ps

module stepper_half_step_controller
   import shsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   // Pipeline registers
   logic    in_valid_ff;
   req_type in_word_ff;
   logic    out_valid_ff;
   rsp_type out_word_ff;

   // Configuration
   logic [DATA_W-1:0]        interval_ff;
   logic signed [DATA_W-1:0] limit_cw_ff;
   logic signed [DATA_W-1:0] limit_ccw_ff;

   // Motor state
   logic signed [DATA_W-1:0] position_ff, position_in;
   dir_type                  dir_ff, dir_in;
   logic [7:0]               mask_ff, mask_in;
   logic [DATA_W-1:0]        remaining_ff, remaining_in;
   logic [DATA_W-1:0]        last_ff, last_in;
   logic                     stopped_ff, stopped_in;
   logic [3:0]               coil_ff, coil_in;
   logic                     stepped_in;
   rsp_type                  rsp_in;

   logic                     advance;
   logic                     tick_due;
   logic                     idle_move;
   logic signed [DATA_W:0]   to_diff;
   logic [DATA_W-1:0]        to_count_ccw;
   dir_type                  step_dir;
   step_type                 step;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;
   assign csr_ready = 1'b1;

   assign tick_due  = (in_word_ff.now_us - last_ff) >= interval_ff;
   assign idle_move = (remaining_ff == '0);
   assign to_diff   = {in_word_ff.amount[DATA_W-1], in_word_ff.amount} -
                      {position_ff[DATA_W-1], position_ff};
   assign to_count_ccw = DATA_W'(-to_diff);

   always_comb begin
      unique case (in_word_ff.opcode)
         OP_STEP_CW:  step_dir = DIR_CW;
         OP_STEP_CCW: step_dir = DIR_CCW;
         default:     step_dir = dir_ff;
      endcase
   end

   shsc_step u_step (
      .position  (position_ff),
      .dir       (step_dir),
      .mask      (mask_ff),
      .limit_cw  (limit_cw_ff),
      .limit_ccw (limit_ccw_ff),
      .result    (step)
   );

   always_comb begin
      position_in  = position_ff;
      dir_in       = dir_ff;
      mask_in      = mask_ff;
      remaining_in = remaining_ff;
      last_in      = last_ff;
      stopped_in   = stopped_ff;
      coil_in      = coil_ff;
      stepped_in   = 1'b0;

      unique case (in_word_ff.opcode)
         OP_TICK: begin
            if (tick_due) begin
               if (!idle_move) begin
                  stepped_in   = step.ok;
                  remaining_in = remaining_ff - DATA_W'(1);
                  last_in      = in_word_ff.now_us;
               end else if (!stopped_ff) begin
                  stopped_in = 1'b1;
                  coil_in    = '0;
               end
            end
         end
         OP_MOVE_CW, OP_MOVE_CCW: begin
            if (idle_move) begin
               stopped_in   = 1'b0;
               dir_in       = (in_word_ff.opcode == OP_MOVE_CW) ? DIR_CW : DIR_CCW;
               remaining_in = (in_word_ff.amount > 0) ? in_word_ff.amount : '0;
               last_in      = in_word_ff.now_us;
            end
         end
         OP_MOVE_TO: begin
            // Ignore a move to the current position
            if (idle_move && to_diff != '0) begin
               stopped_in = 1'b0;
               last_in    = in_word_ff.now_us;
               if (to_diff[DATA_W]) begin
                  dir_in       = DIR_CCW;
                  remaining_in = to_count_ccw;
               end else begin
                  dir_in       = DIR_CW;
                  remaining_in = to_diff[DATA_W-1:0];
               end
            end
         end
         OP_STOP: remaining_in = '0;
         OP_STEP_CW, OP_STEP_CCW: begin
            dir_in     = step_dir;
            stepped_in = step.ok;
         end
         default: ;
      endcase

      // A refused step leaves position, mask and coils alone
      if (stepped_in) begin
         position_in = step.position;
         mask_in     = step.mask;
         coil_in     = step.coils;
      end

      rsp_in.coils        = coil_in;
      rsp_in.position_now = position_in;
      rsp_in.stepped      = stepped_in;
      rsp_in.busy_res     = (remaining_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         interval_ff  <= STEP_INTERVAL_RESET;
         limit_cw_ff  <= LIMIT_CW_RESET;
         limit_ccw_ff <= LIMIT_CCW_RESET;
         position_ff  <= '0;
         dir_ff       <= DIR_NONE;
         mask_ff      <= MASK_RESET;
         remaining_ff <= '0;
         last_ff      <= '0;
         stopped_ff   <= 1'b1;
         coil_ff      <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_STEP_INTERVAL: interval_ff  <= csr_data;
               CSR_LIMIT_CW:      limit_cw_ff  <= csr_data;
               CSR_LIMIT_CCW:     limit_ccw_ff <= csr_data;
               default: ;
            endcase
         end

         if (advance) begin
            position_ff  <= position_in;
            dir_ff       <= dir_in;
            mask_ff      <= mask_in;
            remaining_ff <= remaining_in;
            last_ff      <= last_in;
            stopped_ff   <= stopped_in;
            coil_ff      <= coil_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= rsp_in;
      end
   end

   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(mask_ff))
      else $error("phase mask lost its single set bit");

   a_refused_holds_position: assert property (@(posedge clock) disable iff (reset)
      advance && !stepped_in |-> position_in == position_ff)
      else $error("position changed without a step");

   a_busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_word.busy_res == (remaining_ff != '0))
      else $error("busy flag disagrees with remaining step count");

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room downstream");

endmodule
